@@ rtl/dbr_pkg.sv @@
// Shared types and constants of the dual bridge converter reader.
// No dependencies; the interface, top, lane and filter files refer to it by scoped names.
package dbr_pkg;

    localparam int ALPHA_W     = 16;
    localparam int ALPHA_SHIFT = 16;
    localparam int HP_W        = 8;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int OFIFO_DEPTH = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 8'd1;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd5243;
    localparam logic [HP_W-1:0]    HP_RESET    = 8'd1;

    // What a completed pair of words does to the filters.
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_DISCARD,
        KIND_SEED,
        KIND_UPDATE
    } t_pair_kind;

    // Per-lane status toward the merge logic, valid for the current tick.
    typedef struct packed {
        logic sck;
        logic word_ready;
    } t_lane_ctl;

endpackage

@@ rtl/dbr_if.sv @@
// Valid/ready channel interfaces: tick input, result output, register writes.
// Depends on dbr_pkg for the configuration port widths.
interface dbr_in_if;
    logic valid;
    logic ready;
    logic dt0_level;
    logic dt1_level;
    logic restart;

    modport source (output valid, output dt0_level, output dt1_level, output restart,
                    input ready);
    modport sink   (input valid, input dt0_level, input dt1_level, input restart,
                    output ready);
endinterface

interface dbr_out_if #(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
);
    logic                                  valid;
    logic                                  ready;
    logic                                  sck0_level;
    logic                                  sck1_level;
    logic                                  pair_valid;
    logic signed [SAMPLE_BITS-1:0]           raw0;
    logic signed [SAMPLE_BITS+FRAC_BITS-1:0] filt0;
    logic signed [SAMPLE_BITS-1:0]           raw1;
    logic signed [SAMPLE_BITS+FRAC_BITS-1:0] filt1;

    modport source (output valid, output sck0_level, output sck1_level, output pair_valid,
                    output raw0, output filt0, output raw1, output filt1, input ready);
    modport sink   (input valid, input sck0_level, input sck1_level, input pair_valid,
                    input raw0, input filt0, input raw1, input filt1, output ready);
endinterface

interface dbr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [dbr_pkg::CFG_IDX_W-1:0]    index;
    logic [dbr_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/dual_bridge_adc_reader_iir_top.sv @@
// Dual serial converter reader with exponential moving-average filters: top level.
// Throughput: one tick per cycle while ready; ready follows an 8-beat credit count, not the sink.
// Filter update runs through diff, partial products and sum; pairs are
// at least 50 ticks apart, so the filter state is always settled when the next pair arrives.
// Reset (synchronous, active low): lanes wait for data low, queue empty, alpha 5243, half period 1.
module dual_bridge_adc_reader_iir_top #(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dbr_in_if.sink      i_in,
    dbr_cfg_if.sink     i_cfg,
    dbr_out_if.source   o_out
);

    localparam int FW    = SAMPLE_BITS + FRAC_BITS;
    localparam int OUT_W = 3 + 2 * SAMPLE_BITS + 2 * FW;
    localparam int OCC_W = $clog2(dbr_pkg::OFIFO_DEPTH + 1);

    // Packed result layout, LSB first: sck0, sck1, pair_valid, raw0, filt0, raw1, filt1.
    localparam int OFS_RAW0  = 3;
    localparam int OFS_FILT0 = OFS_RAW0 + SAMPLE_BITS;
    localparam int OFS_RAW1  = OFS_FILT0 + FW;
    localparam int OFS_FILT1 = OFS_RAW1 + SAMPLE_BITS;

    // ---------------------------------------------------------------------------------
    // Configuration registers: user writes while idle, unchecked; always ready, bad index dropped.
    // ---------------------------------------------------------------------------------
    logic [dbr_pkg::ALPHA_W-1:0] r_alpha;
    logic [dbr_pkg::HP_W-1:0]    r_half_period;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha       <= dbr_pkg::ALPHA_RESET;
            r_half_period <= dbr_pkg::HP_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                dbr_pkg::REG_ALPHA:       r_alpha       <= i_cfg.data[dbr_pkg::ALPHA_W-1:0];
                dbr_pkg::REG_HALF_PERIOD: r_half_period <= i_cfg.data[dbr_pkg::HP_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------------------
    // Input beat and credit: occupancy counts every tick accepted but not yet taken at
    // the output, so the pipeline never pushes into a full queue.
    // ---------------------------------------------------------------------------------
    logic             w_adv;
    logic             w_pop;
    logic [OCC_W-1:0] r_occ;

    assign i_in.ready = (r_occ < OCC_W'(dbr_pkg::OFIFO_DEPTH));
    assign w_adv      = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= r_occ + OCC_W'(w_adv) - OCC_W'(w_pop);
        end
    end

    // ---------------------------------------------------------------------------------
    // Two pin sequencer lanes, advanced once per accepted tick.
    // ---------------------------------------------------------------------------------
    dbr_pkg::t_lane_ctl          w_ctl0, w_ctl1;
    logic [SAMPLE_BITS-1:0]      w_word0, w_word1;
    logic                        w_pair;

    // A pair is taken on the tick where both lanes hold a word; take clears both.
    assign w_pair = w_adv && w_ctl0.word_ready && w_ctl1.word_ready;

    dbr_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane0 (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick        (w_adv),
        .i_dt          (i_in.dt0_level),
        .i_half_period (r_half_period),
        .i_take        (w_pair),
        .o_ctl         (w_ctl0),
        .o_word        (w_word0)
    );

    dbr_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane1 (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick        (w_adv),
        .i_dt          (i_in.dt1_level),
        .i_half_period (r_half_period),
        .i_take        (w_pair),
        .o_ctl         (w_ctl1),
        .o_word        (w_word1)
    );

    // ---------------------------------------------------------------------------------
    // Merge: decide what the pair does. Restart applies before the pair of its own tick;
    // the first pair after reset is always dropped.
    // ---------------------------------------------------------------------------------
    logic                r_discarded;
    logic                r_seeded;
    logic                w_seeded_eff;
    dbr_pkg::t_pair_kind w_kind;

    assign w_seeded_eff = r_seeded && !i_in.restart;

    always_comb begin
        if (!w_pair) begin
            w_kind = dbr_pkg::KIND_NONE;
        end else if (!r_discarded) begin
            w_kind = dbr_pkg::KIND_DISCARD;
        end else if (!w_seeded_eff) begin
            w_kind = dbr_pkg::KIND_SEED;
        end else begin
            w_kind = dbr_pkg::KIND_UPDATE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_discarded <= 1'b0;
            r_seeded    <= 1'b0;
        end else if (w_adv) begin
            if (w_kind == dbr_pkg::KIND_DISCARD) begin
                r_discarded <= 1'b1;
            end
            // a seed on this tick wins over a restart of the same tick
            if (w_kind == dbr_pkg::KIND_SEED) begin
                r_seeded <= 1'b1;
            end else if (i_in.restart) begin
                r_seeded <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Filters, one per lane; an update passes the diff and partial product registers first.
    // ---------------------------------------------------------------------------------
    logic signed [FW-1:0] w_filt0, w_filt1;

    dbr_filt #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_filt0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_kind  (w_kind),
        .i_raw   ($signed(w_word0)),
        .i_alpha (r_alpha),
        .o_filt  (w_filt0)
    );

    dbr_filt #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_filt1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_kind  (w_kind),
        .i_raw   ($signed(w_word1)),
        .i_alpha (r_alpha),
        .o_filt  (w_filt1)
    );

    // ---------------------------------------------------------------------------------
    // Result pipeline: three stages that always advance, matching the filter latency.
    // ---------------------------------------------------------------------------------
    logic                   r_v   [3];
    logic                   r_upd [3];
    logic                   r_sck0 [3];
    logic                   r_sck1 [3];
    logic [SAMPLE_BITS-1:0] r_raw0 [3];
    logic [SAMPLE_BITS-1:0] r_raw1 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 3; s++) begin
                r_v[s] <= 1'b0;
            end
        end else begin
            r_v[0] <= w_adv;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_upd[0]  <= (w_kind == dbr_pkg::KIND_UPDATE);
        r_sck0[0] <= w_ctl0.sck;
        r_sck1[0] <= w_ctl1.sck;
        r_raw0[0] <= w_word0;
        r_raw1[0] <= w_word1;
        for (int s = 1; s < 3; s++) begin
            r_upd[s]  <= r_upd[s-1];
            r_sck0[s] <= r_sck0[s-1];
            r_sck1[s] <= r_sck1[s-1];
            r_raw0[s] <= r_raw0[s-1];
            r_raw1[s] <= r_raw1[s-1];
        end
    end

    // Zero the data fields of beats that carry no filtered pair.
    logic             w_pv;
    logic [OUT_W-1:0] w_push_data;
    logic [OUT_W-1:0] w_out_data;
    logic             w_out_valid;
    logic             w_ofifo_full;

    assign w_pv        = r_upd[2];
    assign w_push_data = {
        w_pv ? w_filt1   : {FW{1'b0}},
        w_pv ? r_raw1[2] : {SAMPLE_BITS{1'b0}},
        w_pv ? w_filt0   : {FW{1'b0}},
        w_pv ? r_raw0[2] : {SAMPLE_BITS{1'b0}},
        w_pv,
        r_sck1[2],
        r_sck0[2]
    };

    dbr_ofifo #(.WIDTH(OUT_W), .DEPTH(dbr_pkg::OFIFO_DEPTH)) u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_v[2]),
        .i_data  (w_push_data),
        .i_pop   (o_out.ready),
        .o_valid (w_out_valid),
        .o_full  (w_ofifo_full),
        .o_data  (w_out_data)
    );

    assign w_pop            = w_out_valid && o_out.ready;
    assign o_out.valid      = w_out_valid;
    assign o_out.sck0_level = w_out_data[0];
    assign o_out.sck1_level = w_out_data[1];
    assign o_out.pair_valid = w_out_data[2];
    assign o_out.raw0       = w_out_data[OFS_FILT0-1:OFS_RAW0];
    assign o_out.filt0      = w_out_data[OFS_RAW1-1:OFS_FILT0];
    assign o_out.raw1       = w_out_data[OFS_FILT1-1:OFS_RAW1];
    assign o_out.filt1      = w_out_data[OUT_W-1:OFS_FILT1];

    // ---------------------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------------------
    // The credit count must keep the queue from ever overflowing.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] |-> !w_ofifo_full)
        else $error("result pushed into a full queue");

    // Any beat in the pipeline is covered by the occupancy count.
    a_occ_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[0] || r_v[1] || r_v[2]) |-> (r_occ != '0))
        else $error("pipeline holds a beat the credit count lost");

    // An update may only follow the discard and a seed.
    a_update_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[0] && r_upd[0]) |-> (r_discarded && r_seeded))
        else $error("filter update before discard and seed");

endmodule

@@ rtl/dbr_lane.sv @@
// Pin sequencer of one converter lane: waits for data low, clocks out one word.
// Depends on dbr_pkg (t_lane_ctl, HP_W).
module dbr_lane #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_tick,
    input  logic                        i_dt,
    input  logic [dbr_pkg::HP_W-1:0]    i_half_period,
    input  logic                        i_take,
    output dbr_pkg::t_lane_ctl          o_ctl,
    output logic [SAMPLE_BITS-1:0]      o_word
);

    localparam int CW = $clog2(SAMPLE_BITS + 2);

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_HIGH,
        PH_LOW
    } t_phase;

    t_phase                   r_phase, n_phase;
    logic [CW-1:0]            r_count, n_count;
    logic [dbr_pkg::HP_W-1:0] r_timer, n_timer;
    logic [SAMPLE_BITS-1:0]   r_shift, n_shift;
    logic                     r_ready, n_ready;

    logic [dbr_pkg::HP_W-1:0] w_hp;
    logic                     w_done;
    logic [CW-1:0]            w_count_inc;

    // A zero half period behaves as one tick.
    assign w_hp        = (i_half_period == '0) ? dbr_pkg::HP_W'(1) : i_half_period;
    assign w_done      = ({1'b0, r_timer} + (dbr_pkg::HP_W + 1)'(1)) >= {1'b0, w_hp};
    assign w_count_inc = r_count + CW'(1);

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_timer = r_timer;
        n_shift = r_shift;
        n_ready = r_ready;
        if (i_tick) begin
            case (r_phase)
                PH_WAIT: begin
                    if (!r_ready && !i_dt) begin
                        n_phase = PH_HIGH;
                        n_count = '0;
                        n_timer = '0;
                        n_shift = '0;
                    end
                end
                PH_HIGH: begin
                    if (!w_done) begin
                        n_timer = r_timer + dbr_pkg::HP_W'(1);
                    end else begin
                        n_timer = '0;
                        // sample at the end of the high phase; the gain pulse is not sampled
                        if (r_count < CW'(SAMPLE_BITS)) begin
                            n_shift = {r_shift[SAMPLE_BITS-2:0], i_dt};
                        end
                        n_phase = PH_LOW;
                    end
                end
                PH_LOW: begin
                    if (!w_done) begin
                        n_timer = r_timer + dbr_pkg::HP_W'(1);
                    end else begin
                        n_timer = '0;
                        n_count = w_count_inc;
                        if (w_count_inc >= CW'(SAMPLE_BITS + 1)) begin
                            n_ready = 1'b1;
                            n_phase = PH_WAIT;
                        end else begin
                            n_phase = PH_HIGH;
                        end
                    end
                end
                default: n_phase = PH_WAIT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_count <= '0;
            r_timer <= '0;
            r_shift <= '0;
            r_ready <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_timer <= n_timer;
            r_shift <= n_shift;
            r_ready <= n_ready && !i_take;
        end
    end

    assign o_ctl.sck        = (n_phase == PH_HIGH);
    assign o_ctl.word_ready = n_ready;
    assign o_word           = n_shift;

endmodule

@@ rtl/dbr_filt.sv @@
// Exponential average filter of one lane: seed, or f += floor(alpha * (raw - f) / 2^16).
// Depends on dbr_pkg (t_pair_kind, ALPHA_W, ALPHA_SHIFT). Update passes r_diff, r_plo/r_phi.
module dbr_filt #(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  dbr_pkg::t_pair_kind                    i_kind,
    input  logic signed [SAMPLE_BITS-1:0]          i_raw,
    input  logic [dbr_pkg::ALPHA_W-1:0]            i_alpha,
    output logic signed [SAMPLE_BITS+FRAC_BITS-1:0] o_filt
);

    localparam int AW    = dbr_pkg::ALPHA_W;
    localparam int FW    = SAMPLE_BITS + FRAC_BITS;
    localparam int DW    = FW + 1;
    localparam int LO_W  = DW / 2;
    localparam int HI_W  = DW - LO_W;
    localparam int PLO_W = LO_W + AW;
    localparam int PHI_W = HI_W + AW + 1;
    localparam int SUM_W = DW + AW + 2;

    logic [FW-1:0]    r_filt;
    logic [DW-1:0]    r_diff;
    logic             r_upd1, r_upd2;
    logic [PLO_W-1:0] r_plo;
    logic [PHI_W-1:0] r_phi;

    logic [FW-1:0]    w_raw_ext;
    logic [DW-1:0]    w_diff;
    logic [PHI_W-1:0] w_hi_ext, w_alpha_ext;
    logic [SUM_W-1:0] w_sum;
    logic [FW-1:0]    w_step;

    assign w_raw_ext   = {i_raw, {FRAC_BITS{1'b0}}};
    assign w_diff      = {w_raw_ext[FW-1], w_raw_ext} - {r_filt[FW-1], r_filt};

    // split the difference so each partial product stays narrow
    assign w_hi_ext    = {{(AW + 1){r_diff[DW-1]}}, r_diff[DW-1:LO_W]};
    assign w_alpha_ext = {{(HI_W + 1){1'b0}}, i_alpha};

    assign w_sum  = {r_phi[PHI_W-1], r_phi, {LO_W{1'b0}}}
                  + {{(SUM_W - PLO_W){1'b0}}, r_plo};
    // arithmetic shift right floors toward minus infinity
    assign w_step = w_sum[dbr_pkg::ALPHA_SHIFT+FW-1:dbr_pkg::ALPHA_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upd1 <= 1'b0;
            r_upd2 <= 1'b0;
        end else begin
            r_upd1 <= (i_kind == dbr_pkg::KIND_UPDATE);
            r_upd2 <= r_upd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff <= w_diff;
        r_plo  <= PLO_W'(r_diff[LO_W-1:0]) * PLO_W'(i_alpha);
        r_phi  <= w_hi_ext * w_alpha_ext;
        if (i_kind == dbr_pkg::KIND_SEED) begin
            r_filt <= w_raw_ext;
        end else if (r_upd2) begin
            r_filt <= r_filt + w_step;
        end
    end

    assign o_filt = r_filt;

endmodule

@@ rtl/dbr_ofifo.sv @@
// Result queue between the fixed-latency pipeline and the output channel.
// No package dependency; DEPTH must be a power of two.
module dbr_ofifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;
    logic             w_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign w_pop   = i_pop && o_valid;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            r_count <= r_count + CW'(i_push) - CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
